// ===== rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg: shared definitions for the keyed sum table
// Widths, cell control struct and the saturating adder used by every cell.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int KEY_W           = 16;
    localparam int AMT_W           = 64;
    localparam int CNT_W           = 6;

    // Operation carried by the func field of an input beat.
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // Broadcast control to every cell of the row.
    typedef struct packed {
        logic add;     // an add beat is being accepted this cycle
        logic ins;     // this cell takes the new key
        logic shift;   // take the neighbour's contents (flush)
    } t_cell_ctl;

    // Two's complement add that clamps to the most positive or most negative value.
    function automatic logic [AMT_W-1:0] sat_add(input logic [AMT_W-1:0] a,
                                                 input logic [AMT_W-1:0] b);
        logic [AMT_W-1:0] r;
        r = a + b;
        if ((a[AMT_W-1] == b[AMT_W-1]) && (r[AMT_W-1] != a[AMT_W-1])) begin
            r = a[AMT_W-1] ? {1'b1, {(AMT_W-1){1'b0}}} : {1'b0, {(AMT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/keyed_sum_table_top.sv =====
// ----------------------------------------------------------------------------
// keyed_sum_table_top: group-by-key sum aggregation
// A row of cells holds up to TABLE_DEPTH keys with saturating Q39.24 sums;
// a flush beat streams every entry out in insertion order and empties the table.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Beat contents
//   --------+-----------+--------------------+---------------------------------------
//   input   | in        | i_valid / o_stall  | func, key_id, token_amount, fiat_amount
//   output  | out       | o_valid / i_stall  | out_key, sums, entry_count, overflowed,
//           |           |                    | last
//
// An add beat never stalls the input: every cell compares its key with the incoming
// key in parallel, and the matching cell accumulates (or the next free cell
// loads) at the same clock edge, so adds may follow each other every cycle outside a flush.
// A flush beat holds the input stalled while the row shifts its entries into the
// output register, one entry per cycle while the output is not stalled; an empty
// table gives a single all-zero result. Reset is synchronous and active low; it
// empties the table and the output register at once, with no clearing pass, since
// cells beyond the fill count are never read.
// Input beats are taken while a result still waits in the output register.

module keyed_sum_table_top #(
    parameter int TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_func,
    input  logic        [kst_pkg::KEY_W-1:0]     i_key_id,
    input  logic signed [kst_pkg::AMT_W-1:0]     i_token_amount,
    input  logic signed [kst_pkg::AMT_W-1:0]     i_fiat_amount,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [kst_pkg::KEY_W-1:0]     o_out_key,
    output logic signed [kst_pkg::AMT_W-1:0]     o_token_sum,
    output logic signed [kst_pkg::AMT_W-1:0]     o_fiat_sum,
    output logic        [kst_pkg::CNT_W-1:0]     o_entry_count,
    output logic                                 o_overflowed,
    output logic                                 o_last
);

    // Fill count must be able to hold the depth itself.
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FLUSH = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;       // entries held
    logic                   r_ovf, n_ovf;           // sticky dropped-key flag
    logic [CW-1:0]          r_remain, n_remain;     // entries still to emit in this run
    logic                   r_empty_run, n_empty_run;
    logic [kst_pkg::CNT_W-1:0] r_run_count, n_run_count;
    logic                   r_run_ovf, n_run_ovf;

    // Output register
    logic                             r_valid, n_valid;
    logic        [kst_pkg::KEY_W-1:0] r_okey, n_okey;
    logic signed [kst_pkg::AMT_W-1:0] r_otok, n_otok;
    logic signed [kst_pkg::AMT_W-1:0] r_ofiat, n_ofiat;
    logic [kst_pkg::CNT_W-1:0]        r_ocnt, n_ocnt;
    logic                             r_oovf, n_oovf;
    logic                             r_olast, n_olast;

    // Cell row
    logic        [kst_pkg::KEY_W-1:0] w_key  [TABLE_DEPTH];
    logic signed [kst_pkg::AMT_W-1:0] w_tok  [TABLE_DEPTH];
    logic signed [kst_pkg::AMT_W-1:0] w_fiat [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]           w_match;

    logic w_in_acc;
    logic w_add;
    logic w_hit;
    logic w_out_free;
    logic w_shift;

    assign o_stall    = (r_state == S_FLUSH);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_add      = w_in_acc && (i_func == kst_pkg::FUNC_ADD);
    assign w_hit      = |w_match;
    assign w_out_free = !r_valid || !i_stall;
    // The row advances by one entry each time the output register takes the head cell.
    assign w_shift    = (r_state == S_FLUSH) && w_out_free && !r_empty_run;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        kst_pkg::t_cell_ctl                 w_ctl;
        logic        [kst_pkg::KEY_W-1:0]   w_nb_key;
        logic signed [kst_pkg::AMT_W-1:0]   w_nb_tok;
        logic signed [kst_pkg::AMT_W-1:0]   w_nb_fiat;

        assign w_ctl.add   = w_add;
        assign w_ctl.ins   = w_add && !w_hit && (r_count == CW'(g));
        assign w_ctl.shift = w_shift;

        if (g < TABLE_DEPTH - 1) begin : g_nb
            assign w_nb_key  = w_key[g+1];
            assign w_nb_tok  = w_tok[g+1];
            assign w_nb_fiat = w_fiat[g+1];
        end else begin : g_tail
            // The tail cell takes nothing meaningful; it lies beyond the fill count.
            assign w_nb_key  = '0;
            assign w_nb_tok  = '0;
            assign w_nb_fiat = '0;
        end

        kst_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (CW'(g) < r_count),
            .i_key      (i_key_id),
            .i_tok      (i_token_amount),
            .i_fiat     (i_fiat_amount),
            .i_nb_key   (w_nb_key),
            .i_nb_tok   (w_nb_tok),
            .i_nb_fiat  (w_nb_fiat),
            .o_match    (w_match[g]),
            .o_key      (w_key[g]),
            .o_tok      (w_tok[g]),
            .o_fiat     (w_fiat[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_remain    = r_remain;
        n_empty_run = r_empty_run;
        n_run_count = r_run_count;
        n_run_ovf   = r_run_ovf;
        n_valid     = r_valid;
        n_okey      = r_okey;
        n_otok      = r_otok;
        n_ofiat     = r_ofiat;
        n_ocnt      = r_ocnt;
        n_oovf      = r_oovf;
        n_olast     = r_olast;

        if (!i_stall) begin
            n_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_add && !w_hit) begin
                    if (r_count < CW'(TABLE_DEPTH)) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (w_in_acc && (i_func == kst_pkg::FUNC_FLUSH)) begin
                    // Snapshot the run's summary, then empty the table.
                    n_state     = S_FLUSH;
                    n_remain    = r_count;
                    n_empty_run = (r_count == '0);
                    n_run_count = kst_pkg::CNT_W'(r_count);
                    n_run_ovf   = r_ovf;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_valid = 1'b1;
                    n_ocnt  = r_run_count;
                    n_oovf  = r_run_ovf;
                    if (r_empty_run) begin
                        // Empty table: a single all-zero result closes the run.
                        n_okey  = '0;
                        n_otok  = '0;
                        n_ofiat = '0;
                        n_olast = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_okey   = w_key[0];
                        n_otok   = w_tok[0];
                        n_ofiat  = w_fiat[0];
                        n_olast  = (r_remain == CW'(1));
                        n_remain = r_remain - CW'(1);
                        if (r_remain == CW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remain    <= n_remain;
        r_empty_run <= n_empty_run;
        r_run_count <= n_run_count;
        r_run_ovf   <= n_run_ovf;
        r_okey      <= n_okey;
        r_otok      <= n_otok;
        r_ofiat     <= n_ofiat;
        r_ocnt      <= n_ocnt;
        r_oovf      <= n_oovf;
        r_olast     <= n_olast;
    end

    assign o_valid       = r_valid;
    assign o_out_key     = r_okey;
    assign o_token_sum   = r_otok;
    assign o_fiat_sum    = r_ofiat;
    assign o_entry_count = r_ocnt;
    assign o_overflowed  = r_oovf;
    assign o_last        = r_olast;

endmodule

// ===== rtl/kst_cell.sv =====
// ----------------------------------------------------------------------------
// kst_cell: one entry of the keyed sum table
// Holds a key and two running sums, matches the broadcast key and shifts
// towards the head of the row during a flush.
// ----------------------------------------------------------------------------
module kst_cell (
    input  logic                                 i_clk,
    input  kst_pkg::t_cell_ctl                   i_ctl,
    input  logic                                 i_occupied,
    input  logic        [kst_pkg::KEY_W-1:0]     i_key,
    input  logic signed [kst_pkg::AMT_W-1:0]     i_tok,
    input  logic signed [kst_pkg::AMT_W-1:0]     i_fiat,
    input  logic        [kst_pkg::KEY_W-1:0]     i_nb_key,
    input  logic signed [kst_pkg::AMT_W-1:0]     i_nb_tok,
    input  logic signed [kst_pkg::AMT_W-1:0]     i_nb_fiat,
    output logic                                 o_match,
    output logic        [kst_pkg::KEY_W-1:0]     o_key,
    output logic signed [kst_pkg::AMT_W-1:0]     o_tok,
    output logic signed [kst_pkg::AMT_W-1:0]     o_fiat
);

    logic        [kst_pkg::KEY_W-1:0] r_key,  n_key;
    logic signed [kst_pkg::AMT_W-1:0] r_tok,  n_tok;
    logic signed [kst_pkg::AMT_W-1:0] r_fiat, n_fiat;

    assign o_match = i_occupied && (r_key == i_key);

    always_comb begin
        n_key  = r_key;
        n_tok  = r_tok;
        n_fiat = r_fiat;
        if (i_ctl.shift) begin
            n_key  = i_nb_key;
            n_tok  = i_nb_tok;
            n_fiat = i_nb_fiat;
        end else if (i_ctl.add && o_match) begin
            n_tok  = signed'(kst_pkg::sat_add(r_tok, i_tok));
            n_fiat = signed'(kst_pkg::sat_add(r_fiat, i_fiat));
        end else if (i_ctl.ins) begin
            n_key  = i_key;
            n_tok  = i_tok;
            n_fiat = i_fiat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_tok  <= n_tok;
        r_fiat <= n_fiat;
    end

    assign o_key  = r_key;
    assign o_tok  = r_tok;
    assign o_fiat = r_fiat;

endmodule

// ===== rtl/kst_checker.sv =====
// ----------------------------------------------------------------------------
// kst_checker: port-level checks for the keyed sum table
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module kst_checker #(
    parameter int TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             i_func,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [kst_pkg::KEY_W-1:0]        o_out_key,
    input logic [kst_pkg::CNT_W-1:0]        o_entry_count,
    input logic                             o_overflowed,
    input logic                             o_last
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown straight after reset");

    // An accepted flush beat holds the input side off while the run streams out.
    a_flush_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_func == kst_pkg::FUNC_FLUSH) |=> o_stall)
        else $error("input not stalled after a flush beat");

    // Mid-run results only appear while input is held off.
    a_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open during a flush run");

    // All results of one run carry the same summary.
    a_run_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=>
            !o_valid || ($stable(o_entry_count) && $stable(o_overflowed)))
        else $error("entry count or overflow changed within a run");

    // A zero count can only be the lone result of an empty table.
    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TABLE_DEPTH < 64) && o_valid && (o_entry_count == '0) |->
            o_last && (o_out_key == '0))
        else $error("empty flush result malformed");

endmodule

bind keyed_sum_table_top kst_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_kst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_key     (o_out_key),
    .o_entry_count (o_entry_count),
    .o_overflowed  (o_overflowed),
    .o_last        (o_last)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for keyed_sum_table_top
// Drives add and flush beats with random gaps and output stalls, predicts
// every flushed entry with an in-bench copy of the table, and compares each
// result beat field by field in arrival order.
// ----------------------------------------------------------------------------

module testbench;

    localparam int DEPTH       = kst_pkg::TABLE_DEPTH_DEF;
    localparam int KW          = kst_pkg::KEY_W;
    localparam int AW          = kst_pkg::AMT_W;
    localparam int CW          = kst_pkg::CNT_W;

    // Beat operations carried by i_func.
    localparam logic FUNC_ADD   = kst_pkg::FUNC_ADD;
    localparam logic FUNC_FLUSH = kst_pkg::FUNC_FLUSH;

    localparam logic [AW-1:0] AMT_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] AMT_MIN = {1'b1, {(AW-1){1'b0}}};
    // One whole unit in Q39.24.
    localparam logic [AW-1:0] Q_ONE   = 64'h0000_0000_0100_0000;

    localparam int RANDOM_ITEMS = 85;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 60;
    localparam int CYCLE_LIMIT  = 2000000;

    // One input beat.
    typedef struct packed {
        logic          func;
        logic [KW-1:0] key;
        logic [AW-1:0] token;
        logic [AW-1:0] fiat;
    } t_ledger_beat;

    // One flushed entry, as seen on the output channel.
    typedef struct packed {
        logic [KW-1:0] key;
        logic [AW-1:0] token;
        logic [AW-1:0] fiat;
        logic [CW-1:0] count;
        logic          dropped;
        logic          last;
    } t_entry_row;

    // A row of the directed table: the beat and, where it is obvious, the one
    // entry that a flush must produce.
    typedef struct packed {
        t_ledger_beat beat;
        logic         typed;
        t_entry_row   want;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_func;
    logic        [KW-1:0] i_key_id;
    logic signed [AW-1:0] i_token_amount;
    logic signed [AW-1:0] i_fiat_amount;
    logic                 o_valid;
    logic                 i_stall;
    logic        [KW-1:0] o_out_key;
    logic signed [AW-1:0] o_token_sum;
    logic signed [AW-1:0] o_fiat_sum;
    logic        [CW-1:0] o_entry_count;
    logic                 o_overflowed;
    logic                 o_last;

    keyed_sum_table_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_key_id       (i_key_id),
        .i_token_amount (i_token_amount),
        .i_fiat_amount  (i_fiat_amount),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_key      (o_out_key),
        .o_token_sum    (o_token_sum),
        .o_fiat_sum     (o_fiat_sum),
        .o_entry_count  (o_entry_count),
        .o_overflowed   (o_overflowed),
        .o_last         (o_last)
    );

    // ------------------------------------------------------------------
    // Predicted table state and the store of entries still to arrive.
    // ------------------------------------------------------------------
    logic [KW-1:0] held_key   [DEPTH];
    logic [AW-1:0] held_token [DEPTH];
    logic [AW-1:0] held_fiat  [DEPTH];
    int            held_count;
    logic          key_dropped;

    t_entry_row    flushed_rows[$];   // rows produced by the last predicted beat
    t_entry_row    pending_rows[$];   // rows still owed by the block, oldest first
    t_directed_row directed_rows[$];

    int   fail_count;
    int   cycle_count;
    logic hold_request;
    int   hold_left;
    int   stall_left;
    int   rx_calm_left;
    logic rx_calm;
    logic tx_calm;

    // The clock runs from time zero; every input has a known value at once.
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = FUNC_ADD;
        i_key_id       = '0;
        i_token_amount = '0;
        i_fiat_amount  = '0;
        i_stall        = 1'b0;
        hold_request   = 1'b0;
        hold_left      = 0;
        stall_left     = 0;
        rx_calm_left   = 0;
        rx_calm        = 1'b0;
        tx_calm        = 1'b0;
        fail_count     = 0;
        cycle_count    = 0;
        held_count     = 0;
        key_dropped    = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Should the block lock up, the run ends here rather than hanging.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("keyed_sum_table_top verification failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Signed add clamped to the 64-bit range, worked out on a 65-bit sum.
    function automatic logic [AW-1:0] clamp_sum(input logic [AW-1:0] acc,
                                                input logic [AW-1:0] amt);
        logic [AW:0] wide;
        wide = {acc[AW-1], acc} + {amt[AW-1], amt};
        if (wide[AW] != wide[AW-1]) begin
            return wide[AW] ? AMT_MIN : AMT_MAX;
        end
        return wide[AW-1:0];
    endfunction

    // Applies one beat to the predicted table. A flush leaves its rows in
    // flushed_rows and empties the table.
    function automatic void account_beat(input t_ledger_beat b);
        int         slot;
        t_entry_row row;
        slot = -1;
        flushed_rows.delete();
        if (b.func == FUNC_ADD) begin
            for (int i = 0; i < held_count; i++) begin
                if (slot < 0 && held_key[i] == b.key) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                held_token[slot] = clamp_sum(held_token[slot], b.token);
                held_fiat[slot]  = clamp_sum(held_fiat[slot], b.fiat);
            end else if (held_count < DEPTH) begin
                held_key[held_count]   = b.key;
                held_token[held_count] = b.token;
                held_fiat[held_count]  = b.fiat;
                held_count++;
            end else begin
                key_dropped = 1'b1;
            end
        end else begin
            if (held_count == 0) begin
                // An empty table still answers with one closing row.
                row         = '0;
                row.dropped = key_dropped;
                row.last    = 1'b1;
                flushed_rows.push_back(row);
            end else begin
                for (int i = 0; i < held_count; i++) begin
                    row.key     = held_key[i];
                    row.token   = held_token[i];
                    row.fiat    = held_fiat[i];
                    row.count   = CW'(held_count);
                    row.dropped = key_dropped;
                    row.last    = (i == held_count - 1);
                    flushed_rows.push_back(row);
                end
            end
            held_count  = 0;
            key_dropped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers a beat and holds it until the block takes it. Called at a rising
    // edge; returns at the edge where the beat was accepted, valid still high.
    task automatic send_beat(input t_ledger_beat b, input logic typed,
                             input t_entry_row want);
        i_valid        <= 1'b1;
        i_func         <= b.func;
        i_key_id       <= b.key;
        i_token_amount <= b.token;
        i_fiat_amount  <= b.fiat;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        account_beat(b);
        if (typed) begin
            pending_rows.push_back(want);
        end else begin
            foreach (flushed_rows[i]) begin
                pending_rows.push_back(flushed_rows[i]);
            end
        end
    endtask

    task automatic rest_sender(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Holds the sender back until every owed row has arrived.
    task automatic drain_table();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_rows.size() != 0);
    endtask

    task automatic send_random(input t_ledger_beat b);
        send_beat(b, 1'b0, '0);
        rest_sender(tx_calm ? 0 : idle_span());
    endtask

    function automatic logic [AW-1:0] random_amount();
        case ($urandom_range(0, 6))
            0: return AMT_MAX;
            1: return AMT_MIN;
            2: return AW'($signed($urandom_range(0, 2000)) - 1000) * Q_ONE;
            3: return {1'b0, 3'b111, 28'($urandom), 32'($urandom)};
            4: return {1'b1, 3'b000, 28'($urandom), 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic t_ledger_beat add_beat(input logic [KW-1:0] key);
        t_ledger_beat b;
        b.func  = FUNC_ADD;
        b.key   = key;
        b.token = random_amount();
        b.fiat  = random_amount();
        return b;
    endfunction

    // The stimulus: directed table, a table-full burst under a long output
    // hold, then random groups of adds closed by a flush.
    initial begin
        t_ledger_beat   b;
        t_ledger_beat   flush_beat;
        logic [KW-1:0]  base_key;
        logic [KW-1:0]  pool[$];
        int             n_keys;
        int             n_adds;
        int             sent;

        flush_beat = '{FUNC_FLUSH, 16'h0000, 64'h0, 64'h0};

        // Flush straight after reset: one empty closing row.
        directed_rows.push_back('{flush_beat, 1'b1,
                                  '{16'h0000, 64'h0, 64'h0, 6'd0, 1'b0, 1'b1}});
        // Top key, both sums pushed past the positive and negative limits.
        directed_rows.push_back('{'{FUNC_ADD, 16'hFFFF, AMT_MAX, AMT_MIN}, 1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'hFFFF, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF},
                                  1'b0, '0});
        directed_rows.push_back('{flush_beat, 1'b1,
                                  '{16'hFFFF, AMT_MAX, AMT_MIN, 6'd1, 1'b0, 1'b1}});
        // Key zero, saturating the other way round.
        directed_rows.push_back('{'{FUNC_ADD, 16'h0000, AMT_MIN, AMT_MAX}, 1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'h0000, AMT_MIN, AMT_MAX}, 1'b0, '0});
        directed_rows.push_back('{flush_beat, 1'b1,
                                  '{16'h0000, AMT_MIN, AMT_MAX, 6'd1, 1'b0, 1'b1}});
        // A few keys with sums that cancel and mix, in insertion order.
        directed_rows.push_back('{'{FUNC_ADD, 16'h1234, 5 * Q_ONE, -(3 * Q_ONE)},
                                  1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'hABCD, -(Q_ONE >> 1), Q_ONE}, 1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'h1234, -(5 * Q_ONE), 3 * Q_ONE},
                                  1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'h5555, AMT_MAX, AMT_MAX}, 1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'hABCD, AMT_MIN, 64'h0}, 1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'h5555, 64'h1, AMT_MIN}, 1'b0, '0});
        directed_rows.push_back('{flush_beat, 1'b0, '0});
        // Two flushes back to back: the second sees an emptied table.
        directed_rows.push_back('{flush_beat, 1'b1,
                                  '{16'h0000, 64'h0, 64'h0, 6'd0, 1'b0, 1'b1}});
        directed_rows.push_back('{'{FUNC_ADD, 16'h8000, Q_ONE, 64'hAAAA_AAAA_AAAA_AAAA},
                                  1'b0, '0});
        directed_rows.push_back('{'{FUNC_ADD, 16'h7FFF, -Q_ONE, 64'h5555_5555_5555_5555},
                                  1'b0, '0});
        directed_rows.push_back('{flush_beat, 1'b0, '0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
            rest_sender(idle_span());
        end

        // The sender waits here for the table to empty completely.
        drain_table();

        // Table-full burst: the receiver holds off for a long stretch while
        // every distinct key is loaded, four more new keys are dropped, held
        // keys still accumulate, and the flush backs up into the input.
        hold_request = 1'b1;
        base_key = KW'($urandom);
        for (int i = 0; i < DEPTH + 4; i++) begin
            send_beat(add_beat(base_key + KW'(i)), 1'b0, '0);
        end
        for (int i = 0; i < 4; i++) begin
            send_beat(add_beat(base_key + KW'($urandom_range(0, DEPTH - 1))), 1'b0, '0);
        end
        send_beat(flush_beat, 1'b0, '0);

        // Random groups. Most are well formed: a handful of keys, repeats among
        // them, then a flush. Some fill the table to near or past its depth, and some are
        // noise: stray flushes and adds with unrelated keys.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                send_random(flush_beat);
                sent++;
            end else begin
                n_keys = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 6)
                                                     : $urandom_range(1, 8);
                n_adds = n_keys + $urandom_range(0, n_keys);
                pool.delete();
                for (int i = 0; i < n_keys; i++) begin
                    pool.push_back(KW'($urandom));
                end
                for (int i = 0; i < n_adds; i++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        b = add_beat(KW'($urandom));
                    end else if (i < n_keys) begin
                        b = add_beat(pool[i]);
                    end else begin
                        b = add_beat(pool[$urandom_range(0, n_keys - 1)]);
                    end
                    send_random(b);
                end
                send_random(flush_beat);
                sent += n_adds + 1;
            end
            if ($urandom_range(0, 6) == 0) begin
                drain_table();
            end
        end

        // Leftover adds are closed by one last flush so the table ends empty.
        send_beat(flush_beat, 1'b0, '0);
        drain_table();
        repeat (SETTLE) @(posedge i_clk);

        if (pending_rows.size() != 0) begin
            $error("%0d expected rows never arrived", pending_rows.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("keyed_sum_table_top verification clean");
        end else begin
            $display("keyed_sum_table_top verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random stalls with calm stretches between them, and one
    // long hold-off on request, counted out here in cycles.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (rx_calm_left == 0) begin
            rx_calm      = ($urandom_range(0, 2) == 0);
            rx_calm_left = $urandom_range(50, 300);
        end else begin
            rx_calm_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall    <= 1'b0;
            stall_left = rx_calm ? 0 : idle_span();
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted result beat against the oldest owed row.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [AW-1:0] want,
                               input logic [AW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_entry_row want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rows.size() == 0) begin
                $error("result beat for key %h with nothing expected", o_out_key);
                fail_count++;
            end else begin
                want = pending_rows.pop_front();
                check_field("out_key",     AW'(want.key),     AW'(o_out_key));
                check_field("token_sum",   want.token,        o_token_sum);
                check_field("fiat_sum",    want.fiat,         o_fiat_sum);
                check_field("entry_count", AW'(want.count),   AW'(o_entry_count));
                check_field("overflowed",  AW'(want.dropped), AW'(o_overflowed));
                check_field("last",        AW'(want.last),    AW'(o_last));
            end
        end
    end

endmodule
